@@ design/hbw_pkg.sv @@
// Shared types, constants and helpers for the task heartbeat watchdog.
package hbw_pkg;

   // Sizes of the slot array, the counters and the register and port fields
   localparam int NUM_SLOTS   = 32;
   localparam int COUNT_WIDTH = 16;
   localparam int START_WIDTH = 16;
   localparam int MASK_WIDTH  = 32;
   localparam int SLOT_WIDTH  = 5;
   localparam int LOG2_WIDTH  = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 40;

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAST_MASK   = 3'd0,
      CSR_SLOW_MASK   = 3'd1,
      CSR_FAST_LOG2   = 3'd2,
      CSR_SLOW_LOG2   = 3'd3,
      CSR_STARTUP     = 3'd4,
      CSR_OWN_SLOT    = 3'd5
   } csr_index_type;

   // Reset values of the configuration registers
   localparam logic [MASK_WIDTH-1:0]  FAST_MASK_RST = '0;
   localparam logic [MASK_WIDTH-1:0]  SLOW_MASK_RST = '0;
   localparam logic [LOG2_WIDTH-1:0]  FAST_LOG2_RST = 4'd5;
   localparam logic [LOG2_WIDTH-1:0]  SLOW_LOG2_RST = 4'd8;
   localparam logic [START_WIDTH-1:0] STARTUP_RST   = 16'd400;
   localparam logic [SLOT_WIDTH-1:0]  OWN_SLOT_RST  = 5'd0;

   // Word kinds on the request side
   localparam logic REQ_HEARTBEAT = 1'b0;
   localparam logic REQ_TICK      = 1'b1;

   typedef struct packed {
      logic [MASK_WIDTH-1:0]  fast_mask;
      logic [MASK_WIDTH-1:0]  slow_mask;
      logic [LOG2_WIDTH-1:0]  fast_log2;
      logic [LOG2_WIDTH-1:0]  slow_log2;
      logic [START_WIDTH-1:0] startup_ticks;
      logic [SLOT_WIDTH-1:0]  own_slot;
   } cfg_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0]   alive;
      logic [COUNT_WIDTH-1:0] tick_count;
      logic [START_WIDTH-1:0] startup_count;
      logic                   halt;
   } state_type;

   typedef struct packed {
      logic                  req_type;
      logic [SLOT_WIDTH-1:0] slot_id;
      logic                  power_down;
      logic                  reset_command;
      logic                  mem_error;
   } item_type;

   typedef struct packed {
      logic [MASK_WIDTH-1:0] missing_mask;
      logic                  halted;
      logic                  kick;
   } result_type;

   // True when the low log2 bits of the counter are all zero
   function automatic logic period_due(logic [COUNT_WIDTH-1:0] count,
                                       logic [LOG2_WIDTH-1:0]  log2p);
      logic [COUNT_WIDTH-1:0] low;
      for (int i = 0; i < COUNT_WIDTH; i++) begin
         low[i] = (i < int'(log2p));
      end
      return (count & low) == '0;
   endfunction

endpackage

@@ design/hbw_core.sv @@
// Next-state and result logic for one heartbeat or tick word.
module hbw_core (
   input  hbw_pkg::cfg_type    cfg,
   input  hbw_pkg::state_type  cur,
   input  hbw_pkg::item_type   item,
   output hbw_pkg::state_type  nxt,
   output hbw_pkg::result_type res
);

   logic [hbw_pkg::SLOT_WIDTH-1:0] mark_slot;
   logic [hbw_pkg::NUM_SLOTS-1:0]  alive_mark;
   logic [hbw_pkg::NUM_SLOTS-1:0]  fast_sel;
   logic [hbw_pkg::NUM_SLOTS-1:0]  slow_sel;
   logic [hbw_pkg::NUM_SLOTS-1:0]  miss_fast;
   logic [hbw_pkg::NUM_SLOTS-1:0]  miss_slow;
   logic [hbw_pkg::NUM_SLOTS-1:0]  alive_fast;
   logic [hbw_pkg::NUM_SLOTS-1:0]  alive_slow;
   logic [hbw_pkg::NUM_SLOTS-1:0]  miss_all;
   logic                           in_startup;

   // Mark the reporting slot (or the own slot on a tick) alive
   always_comb begin
      mark_slot  = (item.req_type == hbw_pkg::REQ_TICK) ? cfg.own_slot : item.slot_id;
      alive_mark = cur.alive;
      if (32'(mark_slot) < hbw_pkg::NUM_SLOTS) begin
         alive_mark = cur.alive | (hbw_pkg::NUM_SLOTS'(1) << mark_slot);
      end
   end

   // Test fast slots first, then slow slots on what is left
   always_comb begin
      fast_sel   = hbw_pkg::period_due(cur.tick_count, cfg.fast_log2)
                   ? cfg.fast_mask[hbw_pkg::NUM_SLOTS-1:0] : '0;
      slow_sel   = hbw_pkg::period_due(cur.tick_count, cfg.slow_log2)
                   ? cfg.slow_mask[hbw_pkg::NUM_SLOTS-1:0] : '0;
      miss_fast  = fast_sel & ~alive_mark;
      alive_fast = alive_mark & ~fast_sel;
      miss_slow  = slow_sel & ~alive_fast;
      alive_slow = alive_fast & ~slow_sel;
      miss_all   = miss_fast | miss_slow;
   end

   assign in_startup = cur.startup_count < cfg.startup_ticks;

   // Pick the outcome of this word
   always_comb begin
      nxt              = cur;
      res.kick         = 1'b0;
      res.missing_mask = '0;
      if (!cur.halt) begin
         nxt.alive = alive_mark;
         if (item.req_type == hbw_pkg::REQ_TICK) begin
            priority if (in_startup) begin
               nxt.startup_count = cur.startup_count + hbw_pkg::START_WIDTH'(1);
               nxt.tick_count    = '0;
               res.kick          = 1'b1;
            end else if (item.power_down) begin
               nxt.alive = alive_mark;
            end else if (item.reset_command) begin
               nxt.halt = 1'b1;
            end else begin
               nxt.alive        = alive_slow;
               res.missing_mask = hbw_pkg::MASK_WIDTH'(miss_all);
               if ((miss_all != '0) || item.mem_error) begin
                  nxt.halt = 1'b1;
               end else begin
                  res.kick       = 1'b1;
                  nxt.tick_count = cur.tick_count + hbw_pkg::COUNT_WIDTH'(1);
               end
            end
         end
      end
      res.halted = nxt.halt;
   end

endmodule

@@ design/hbw_skid.sv @@
// Two-entry output buffer: result register plus skid register.
module hbw_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hbw_pkg::result_type push_word,
   output logic                can_push,
   output logic                out_valid,
   input  logic                out_ready,
   output hbw_pkg::result_type out_word
);

   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   hbw_pkg::result_type out_word_ff, out_word_in;
   hbw_pkg::result_type skid_word_ff, skid_word_in;

   // Refill the result register from skid first, then from the new word
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_word_in  = push_word;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_word_in  = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign can_push  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

endmodule

@@ design/task_heartbeat_watchdog_unit.sv @@
// Top level of the task heartbeat watchdog.
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/tready     tuser kind, tdata slot and tick flags
//   rsp      out        rsp_tvalid/tready     tdata kick, halted, missing mask
//   csr      in         csr_wr_en             csr_index, csr_wdata
//
// The slot and counter registers update at the accept edge and the result is
// registered at the same edge; one word per cycle while req_tready stays high.
// Synchronous reset clears the slots, counters, halt latch and output buffer and
// loads the register defaults. A stalled rsp side is absorbed by a skid register;
// req_tready drops only once both output registers hold words.
module task_heartbeat_watchdog_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tuser,  // req_type
   // slot_id[4:0], power_down[5], reset_command[6], mem_error[7]
   input  logic [hbw_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // kick[0], halted[1], missing_mask[33:2], zero fill[39:34]
   output logic [hbw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [hbw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hbw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   hbw_pkg::cfg_type    cfg_ff, cfg_in;
   hbw_pkg::state_type  state_ff, state_in;
   hbw_pkg::state_type  state_nxt;
   hbw_pkg::item_type   item;
   hbw_pkg::result_type result;
   hbw_pkg::result_type out_word;
   logic                req_accept;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            hbw_pkg::CSR_FAST_MASK: cfg_in.fast_mask = csr_wdata;
            hbw_pkg::CSR_SLOW_MASK: cfg_in.slow_mask = csr_wdata;
            hbw_pkg::CSR_FAST_LOG2: cfg_in.fast_log2 = csr_wdata[hbw_pkg::LOG2_WIDTH-1:0];
            hbw_pkg::CSR_SLOW_LOG2: cfg_in.slow_log2 = csr_wdata[hbw_pkg::LOG2_WIDTH-1:0];
            hbw_pkg::CSR_STARTUP:
               cfg_in.startup_ticks = csr_wdata[hbw_pkg::START_WIDTH-1:0];
            hbw_pkg::CSR_OWN_SLOT:  cfg_in.own_slot = csr_wdata[hbw_pkg::SLOT_WIDTH-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_mask     <= hbw_pkg::FAST_MASK_RST;
         cfg_ff.slow_mask     <= hbw_pkg::SLOW_MASK_RST;
         cfg_ff.fast_log2     <= hbw_pkg::FAST_LOG2_RST;
         cfg_ff.slow_log2     <= hbw_pkg::SLOW_LOG2_RST;
         cfg_ff.startup_ticks <= hbw_pkg::STARTUP_RST;
         cfg_ff.own_slot      <= hbw_pkg::OWN_SLOT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the request word
   always_comb begin
      item.req_type      = req_tuser;
      item.slot_id       = req_tdata[4:0];
      item.power_down    = req_tdata[5];
      item.reset_command = req_tdata[6];
      item.mem_error     = req_tdata[7];
   end

   assign req_accept = req_tvalid && req_tready;

   hbw_core u_core (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item),
      .nxt  (state_nxt),
      .res  (result)
   );

   // Advance watchdog state on each accepted word
   assign state_in = req_accept ? state_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   hbw_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_word (result),
      .can_push  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   // Pack the result word
   assign rsp_tdata = {6'd0, out_word.missing_mask, out_word.halted, out_word.kick};

endmodule

@@ design/task_heartbeat_watchdog_unit_checker.sv @@
// Port-level assertions for the task heartbeat watchdog, bound to the top level.
module task_heartbeat_watchdog_unit_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [hbw_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic rsp_accept;
   logic seen_halt_ff, seen_halt_in;

   assign rsp_accept = rsp_tvalid && rsp_tready;

   // Remember a delivered halt until reset
   assign seen_halt_in = seen_halt_ff || (rsp_accept && rsp_tdata[1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else begin
         seen_halt_ff <= seen_halt_in;
      end
   end

   // Halt stays latched in every later word
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && seen_halt_ff |-> rsp_tdata[1])
      else $error("halted dropped after a halt word");

   // A kick never comes with a halt or a missing slot
   a_kick_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && rsp_tdata[0] |-> !rsp_tdata[1] && (rsp_tdata[33:2] == '0))
      else $error("kick together with halt or missing slots");

   // Missing slots always halt
   a_miss_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && (rsp_tdata[33:2] != '0) |-> rsp_tdata[1])
      else $error("missing slots without halt");

   // Output buffer empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present right after reset");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

endmodule

bind task_heartbeat_watchdog_unit task_heartbeat_watchdog_unit_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
